>>> rtl/core/bp_pkg.sv
`timescale 1ns / 1ps

package bp_pkg;

    // fixed field widths
    localparam int COORD_W   = 24;
    localparam int RADIUS_W  = 23;
    localparam int SHIFT_W   = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // internal arithmetic widths
    localparam int SQ_W   = 2 * COORD_W;
    localparam int NORM_W = COORD_W;
    localparam int NUM_W  = RADIUS_W + COORD_W;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORM_MODE = 2'd0,
        CFG_SHIFT_X   = 2'd1,
        CFG_SHIFT_Y   = 2'd2,
        CFG_RADIUS    = 2'd3
    } t_cfg_idx;

    // payload words
    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      was_outside;
    } t_out_word;

    // data handed between square root cells
    typedef struct packed {
        logic                      valid;
        logic [SQ_W-1:0]           rem;
        logic [NORM_W-1:0]         root;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COORD_W-1:0]        ax;
        logic [COORD_W-1:0]        ay;
    } t_sqrt_lane;

    // data handed between divider cells
    typedef struct packed {
        logic                      valid;
        logic [NUM_W-1:0]          rem_x;
        logic [NUM_W-1:0]          rem_y;
        logic [COORD_W-1:0]        q_x;
        logic [COORD_W-1:0]        q_y;
        logic [NORM_W-1:0]         d;
        logic                      hit;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_div_lane;

endpackage

>>> rtl/core/bp_sqrt_cell.sv
`timescale 1ns / 1ps

module bp_sqrt_cell
    import bp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_sqrt_lane i_lane,
    output t_sqrt_lane o_lane
);

    t_sqrt_lane      r_lane;
    t_sqrt_lane      n_lane;
    logic [SQ_W-1:0] trial;

    // one root bit: try (2*root + 2^b) * 2^b against the remainder
    always_comb begin
        trial  = ({{(SQ_W-NORM_W){1'b0}}, i_lane.root} << (BIT + 1))
               | (SQ_W'(1) << (2 * BIT));
        n_lane = i_lane;
        if (i_lane.rem >= trial) begin
            n_lane.rem  = i_lane.rem - trial;
            n_lane.root = i_lane.root | (NORM_W'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

>>> rtl/core/bp_div_cell.sv
`timescale 1ns / 1ps

module bp_div_cell
    import bp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    t_div_lane        r_lane;
    t_div_lane        n_lane;
    logic [NUM_W-1:0] sub;

    // one quotient bit for both coordinates, shared divisor
    always_comb begin
        sub    = {{(NUM_W-NORM_W){1'b0}}, i_lane.d} << BIT;
        n_lane = i_lane;
        if (i_lane.rem_x >= sub) begin
            n_lane.rem_x = i_lane.rem_x - sub;
            n_lane.q_x   = i_lane.q_x | (COORD_W'(1) << BIT);
        end
        if (i_lane.rem_y >= sub) begin
            n_lane.rem_y = i_lane.rem_y - sub;
            n_lane.q_y   = i_lane.q_y | (COORD_W'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

>>> rtl/core/ball_projection_2d.sv
`timescale 1ns / 1ps
// pipeline: 3 entry stages, 24 square root cells, 1 scaling multiply, 24 divider
// cells and 1 output stage between input accept and output valid
// throughput: one word per cycle unless the output stalls; every cell moves its lane
// on each enabled cycle, and the whole pipe holds only while a finished word waits
// reset: synchronous active low, clears all valid bits and loads register defaults

module ball_projection_2d
    import bp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word
);

    localparam int EW = COORD_W + 2;
    localparam int SW = EW + 1;

    logic                       r_norm_mode;
    logic signed [SHIFT_W-1:0]  r_shift_x;
    logic signed [SHIFT_W-1:0]  r_shift_y;
    logic [RADIUS_W-1:0]        r_radius;

    logic                       en;

    logic                       r0_valid;
    logic signed [COORD_W-1:0]  r0_x;
    logic signed [COORD_W-1:0]  r0_y;
    logic [COORD_W-1:0]         ax0;
    logic [COORD_W-1:0]         ay0;

    logic                       r1_valid;
    logic signed [COORD_W-1:0]  r1_x;
    logic signed [COORD_W-1:0]  r1_y;
    logic [COORD_W-1:0]         r1_ax;
    logic [COORD_W-1:0]         r1_ay;
    logic [SQ_W-1:0]            r1_sqx;
    logic [SQ_W-1:0]            r1_sqy;

    t_sqrt_lane                 sq [0:NORM_W];
    t_sqrt_lane                 r2;
    t_sqrt_lane                 sq_end;
    t_div_lane                  dv [0:COORD_W];
    t_div_lane                  r3;
    t_div_lane                  fin;

    logic signed [EW-1:0]       ex, ey, rad_e, qx_e, qy_e, px, py;
    logic signed [SW-1:0]       sum_x, sum_y;
    logic                       hit;
    logic                       r_out_valid;
    t_out_word                  r_out_word;
    t_out_word                  n_out_word;

    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_mode <= 1'b0;
            r_shift_x   <= '0;
            r_shift_y   <= '0;
            r_radius    <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NORM_MODE: r_norm_mode <= i_cfg_data[0];
                CFG_SHIFT_X:   r_shift_x   <= i_cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_Y:   r_shift_y   <= i_cfg_data[SHIFT_W-1:0];
                CFG_RADIUS:    r_radius    <= i_cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // the pipe moves unless the output word is stalled
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= i_in_valid;
            r0_x     <= i_in_word.in_x;
            r0_y     <= i_in_word.in_y;
        end
    end

    // magnitudes, the most negative value fits unsigned
    assign ax0 = r0_x[COORD_W-1] ? COORD_W'(-r0_x) : COORD_W'(r0_x);
    assign ay0 = r0_y[COORD_W-1] ? COORD_W'(-r0_y) : COORD_W'(r0_y);

    // squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= r0_valid;
            r1_x     <= r0_x;
            r1_y     <= r0_y;
            r1_ax    <= ax0;
            r1_ay    <= ay0;
            r1_sqx   <= SQ_W'(ax0) * SQ_W'(ax0);
            r1_sqy   <= SQ_W'(ay0) * SQ_W'(ay0);
        end
    end

    // sum of squares loads the root chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2.valid <= 1'b0;
        end else if (en) begin
            r2.valid <= r1_valid;
            r2.rem   <= r1_sqx + r1_sqy;
            r2.root  <= '0;
            r2.x     <= r1_x;
            r2.y     <= r1_y;
            r2.ax    <= r1_ax;
            r2.ay    <= r1_ay;
        end
    end

    assign sq[0] = r2;

    // square root chain, top bit first
    for (genvar k = 0; k < NORM_W; k++) begin : g_sqrt
        bp_sqrt_cell #(
            .BIT(NORM_W - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_lane (sq[k]),
            .o_lane (sq[k+1])
        );
    end

    assign sq_end = sq[NORM_W];

    // compare with radius and form the scaled numerators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3.valid <= 1'b0;
        end else if (en) begin
            r3.valid <= sq_end.valid;
            r3.rem_x <= NUM_W'(r_radius) * NUM_W'(sq_end.ax);
            r3.rem_y <= NUM_W'(r_radius) * NUM_W'(sq_end.ay);
            r3.q_x   <= '0;
            r3.q_y   <= '0;
            r3.d     <= sq_end.root;
            r3.hit   <= sq_end.root > NORM_W'(r_radius);
            r3.x     <= sq_end.x;
            r3.y     <= sq_end.y;
        end
    end

    assign dv[0] = r3;

    // divider chain, top quotient bit first
    for (genvar k = 0; k < COORD_W; k++) begin : g_div
        bp_div_cell #(
            .BIT(COORD_W - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_lane (dv[k]),
            .o_lane (dv[k+1])
        );
    end

    assign fin = dv[COORD_W];

    // projection select, shift and saturation
    always_comb begin
        ex    = EW'(fin.x);
        ey    = EW'(fin.y);
        rad_e = signed'({{(EW-RADIUS_W){1'b0}}, r_radius});
        qx_e  = signed'({{(EW-COORD_W){1'b0}}, fin.q_x});
        qy_e  = signed'({{(EW-COORD_W){1'b0}}, fin.q_y});
        px    = ex;
        py    = ey;
        hit   = 1'b0;
        if (!r_norm_mode) begin
            if (fin.hit) begin
                px  = fin.x[COORD_W-1] ? -qx_e : qx_e;
                py  = fin.y[COORD_W-1] ? -qy_e : qy_e;
                hit = 1'b1;
            end
        end else begin
            if (ex > rad_e) begin
                px  = rad_e;
                hit = 1'b1;
            end else if (ex < -rad_e) begin
                px  = -rad_e;
                hit = 1'b1;
            end
            if (ey > rad_e) begin
                py  = rad_e;
                hit = 1'b1;
            end else if (ey < -rad_e) begin
                py  = -rad_e;
                hit = 1'b1;
            end
        end
        sum_x = SW'(px) + SW'(r_shift_x);
        sum_y = SW'(py) + SW'(r_shift_y);
        if (sum_x > SAT_HI) begin
            sum_x = SAT_HI;
        end else if (sum_x < SAT_LO) begin
            sum_x = SAT_LO;
        end
        if (sum_y > SAT_HI) begin
            sum_y = SAT_HI;
        end else if (sum_y < SAT_LO) begin
            sum_y = SAT_LO;
        end
        n_out_word.out_x       = sum_x[COORD_W-1:0];
        n_out_word.out_y       = sum_y[COORD_W-1:0];
        n_out_word.was_outside = hit;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin.valid;
            r_out_word  <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> rtl/core/bp_checker.sv
`timescale 1ns / 1ps

module bp_checker
    import bp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // a stalled output word stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    // a stalled output word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // input is held off exactly while the output is stalled
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // handshakes are known, and so is a word while it is offered
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_in_valid, o_in_ready, o_out_valid})
        && (!o_out_valid || !$isunknown(o_out_word)))
        else $error("unknown handshake or output word");

endmodule

bind ball_projection_2d bp_checker u_bp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_word (o_out_word)
);
